// ===== rtl/brc_pkg.sv =====
// Shared widths, constants, codes and beat types for the barometer compensation block.
package brc_pkg;

   localparam int UT_W       = 16;
   localparam int UP_W       = 16;
   localparam int TEMP_W     = 16;
   localparam int PRESS_W    = 18;
   localparam int COEF_W     = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam int X1_W   = 18;
   localparam int TNUM_W = 27;
   localparam int TDEN_W = 18;
   localparam int B5_W   = 28;
   localparam int B6_W   = 28;
   localparam int SQ_W   = 42;
   localparam int PNUM_W = 32;
   localparam int PDEN_W = 17;
   localparam int P_W    = 33;

   localparam int MC_SHIFT    = 11;
   localparam int B6_OFFSET   = 4000;
   localparam int PRESS_SCALE = 50000;
   localparam int B4_BIAS     = 32768;
   localparam int K1          = 3038;
   localparam int K2          = -7357;
   localparam int K3          = 3791;
   localparam int TEMP_MAX    = 32767;
   localparam int TEMP_MIN    = -32768;
   localparam int PRESS_MAX   = 262143;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AC1   = 4'd0,
      CSR_AC2   = 4'd1,
      CSR_AC3   = 4'd2,
      CSR_AC4   = 4'd3,
      CSR_AC5   = 4'd4,
      CSR_AC6   = 4'd5,
      CSR_B1_B2 = 4'd6,
      CSR_MC_MD = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [UT_W-1:0] ut;
      logic [UP_W-1:0] up;
   } req_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_tenths;
      logic [PRESS_W-1:0]       pressure_pa;
      logic                     math_error;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] ac1;
      logic signed [COEF_W-1:0] ac2;
      logic signed [COEF_W-1:0] ac3;
      logic [COEF_W-1:0]        ac4;
      logic [COEF_W-1:0]        ac5;
      logic [COEF_W-1:0]        ac6;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] mc;
      logic signed [COEF_W-1:0] md;
   } coef_type;

   typedef struct packed {
      logic signed [X1_W-1:0] x1;
      logic [UP_W-1:0]        up;
      logic                   neg;
      logic                   err;
   } tdiv_side_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic                     dbl;
      logic                     err;
   } pdiv_side_type;

endpackage

// ===== rtl/brc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module brc_div #(
   parameter int NUM_W  = brc_pkg::TNUM_W,
   parameter int DEN_W  = brc_pkg::TDEN_W,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic [NUM_W-1:0]  valid_ff;
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W-1];
   logic [DEN_W-1:0]  rem_ff  [NUM_W-1];
   logic [DEN_W-1:0]  den_ff  [NUM_W-1];

   for (genvar s = 0; s < NUM_W; s++) begin : g_step
      logic              valid_prev;
      logic [NUM_W-1:0]  num_prev;
      logic [NUM_W-1:0]  quo_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  quo_in;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign num_prev   = in_num;
         assign quo_prev   = '0;
         assign rem_prev   = '0;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign num_prev   = num_ff[s-1];
         assign quo_prev   = quo_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign den_prev   = den_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      assign trial  = {rem_prev, num_prev[NUM_W-1-s]};
      assign diff   = trial - {1'b0, den_prev};
      assign rem_in = diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
      assign quo_in = {quo_prev[NUM_W-2:0], ~diff[DEN_W]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_prev;
         end
      end

      if (s < NUM_W-1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               num_ff[s] <= num_prev;
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_prev;
            end
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== rtl/brc_coef.sv =====
// Stages between the two dividers: B5, temperature, B6, B3, B4 and B7 terms.
module brc_coef (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  brc_pkg::coef_type            coef,
   input  logic                         in_valid,
   input  logic [brc_pkg::TNUM_W-1:0]   in_quo,
   input  brc_pkg::tdiv_side_type       in_side,
   output logic                         out_valid,
   output logic [brc_pkg::PNUM_W-1:0]   out_num,
   output logic [brc_pkg::PDEN_W-1:0]   out_den,
   output brc_pkg::pdiv_side_type       out_side
);
   import brc_pkg::*;

   localparam int PB_W   = COEF_W + B6_W;
   localparam int X1A_W  = PB_W - 11;
   localparam int X1C_W  = PB_W - 13;
   localparam int M_W    = COEF_W + SQ_W + 1;
   localparam int M2S_W  = M_W - 11;
   localparam int M1S_W  = M_W - 16;
   localparam int X3A_W  = M2S_W + 1;
   localparam int N_W    = X3A_W + 1;
   localparam int NADJ_W = PNUM_W + 2;

   logic [8:1] valid_ff;

   // stage 1: B5
   logic signed [B5_W-1:0] c1_x2;
   logic signed [B5_W-1:0] c1_b5_in;
   logic signed [B5_W-1:0] c1_b5_ff;
   logic [UP_W-1:0]        c1_up_ff;
   logic                   c1_err_ff;

   assign c1_x2    = in_side.neg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
   assign c1_b5_in = B5_W'(in_side.x1) + c1_x2;

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_b5_ff  <= c1_b5_in;
         c1_up_ff  <= in_side.up;
         c1_err_ff <= in_side.err;
      end
   end

   // stage 2: temperature and B6
   logic signed [B5_W-1:0]   c2_tsum;
   logic signed [B5_W-1:0]   c2_t;
   logic signed [TEMP_W-1:0] c2_temp_in;
   logic signed [B6_W-1:0]   c2_b6_in;
   logic signed [TEMP_W-1:0] c2_temp_ff;
   logic signed [B6_W-1:0]   c2_b6_ff;
   logic [UP_W-1:0]          c2_up_ff;
   logic                     c2_err_ff;

   assign c2_tsum  = c1_b5_ff + B5_W'(8);
   assign c2_t     = c2_tsum >>> 4;
   assign c2_b6_in = B6_W'(c1_b5_ff) - B6_W'(B6_OFFSET);

   always_comb begin
      if (c2_t > B5_W'(TEMP_MAX)) begin
         c2_temp_in = TEMP_W'(TEMP_MAX);
      end else if (c2_t < B5_W'(TEMP_MIN)) begin
         c2_temp_in = TEMP_W'(TEMP_MIN);
      end else begin
         c2_temp_in = TEMP_W'(c2_t);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c2_temp_ff <= c2_temp_in;
         c2_b6_ff   <= c2_b6_in;
         c2_up_ff   <= c1_up_ff;
         c2_err_ff  <= c1_err_ff;
      end
   end

   // stage 3: B6 products
   logic signed [2*B6_W-1:0] c3_sqp_in;
   logic signed [PB_W-1:0]   c3_p2_in;
   logic signed [PB_W-1:0]   c3_p3_in;
   logic signed [2*B6_W-1:0] c3_sqp_ff;
   logic signed [PB_W-1:0]   c3_p2_ff;
   logic signed [PB_W-1:0]   c3_p3_ff;
   logic signed [TEMP_W-1:0] c3_temp_ff;
   logic [UP_W-1:0]          c3_up_ff;
   logic                     c3_err_ff;

   assign c3_sqp_in = c2_b6_ff * c2_b6_ff;
   assign c3_p2_in  = coef.ac2 * c2_b6_ff;
   assign c3_p3_in  = coef.ac3 * c2_b6_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         c3_sqp_ff  <= c3_sqp_in;
         c3_p2_ff   <= c3_p2_in;
         c3_p3_ff   <= c3_p3_in;
         c3_temp_ff <= c2_temp_ff;
         c3_up_ff   <= c2_up_ff;
         c3_err_ff  <= c2_err_ff;
      end
   end

   // stage 4: B1 and B2 products on the square term
   logic [SQ_W-1:0]          c4_sq;
   logic signed [M_W-1:0]    c4_m2;
   logic signed [M_W-1:0]    c4_m1;
   logic signed [M2S_W-1:0]  c4_m2s_ff;
   logic signed [M1S_W-1:0]  c4_m1s_ff;
   logic signed [X1A_W-1:0]  c4_x1a_ff;
   logic signed [X1C_W-1:0]  c4_x1c_ff;
   logic signed [TEMP_W-1:0] c4_temp_ff;
   logic [UP_W-1:0]          c4_up_ff;
   logic                     c4_err_ff;

   assign c4_sq = c3_sqp_ff[SQ_W+11:12];
   assign c4_m2 = coef.b2 * $signed({1'b0, c4_sq});
   assign c4_m1 = coef.b1 * $signed({1'b0, c4_sq});

   always_ff @(posedge clock) begin
      if (advance) begin
         c4_m2s_ff  <= M2S_W'(c4_m2 >>> 11);
         c4_m1s_ff  <= M1S_W'(c4_m1 >>> 16);
         c4_x1a_ff  <= X1A_W'(c3_p2_ff >>> 11);
         c4_x1c_ff  <= X1C_W'(c3_p3_ff >>> 13);
         c4_temp_ff <= c3_temp_ff;
         c4_up_ff   <= c3_up_ff;
         c4_err_ff  <= c3_err_ff;
      end
   end

   // stage 5: X3 sums
   logic signed [X3A_W-1:0]  c5_x3a_in;
   logic signed [M1S_W:0]    c5_s;
   logic [PNUM_W-1:0]        c5_x3b_in;
   logic signed [X3A_W-1:0]  c5_x3a_ff;
   logic [PNUM_W-1:0]        c5_x3b_ff;
   logic signed [TEMP_W-1:0] c5_temp_ff;
   logic [UP_W-1:0]          c5_up_ff;
   logic                     c5_err_ff;

   assign c5_x3a_in = X3A_W'(c4_m2s_ff) + X3A_W'(c4_x1a_ff);
   assign c5_s      = (M1S_W+1)'(c4_m1s_ff) + (M1S_W+1)'(c4_x1c_ff) + (M1S_W+1)'(2);
   assign c5_x3b_in = c5_s[PNUM_W+1:2] + PNUM_W'(B4_BIAS);

   always_ff @(posedge clock) begin
      if (advance) begin
         c5_x3a_ff  <= c5_x3a_in;
         c5_x3b_ff  <= c5_x3b_in;
         c5_temp_ff <= c4_temp_ff;
         c5_up_ff   <= c4_up_ff;
         c5_err_ff  <= c4_err_ff;
      end
   end

   // stage 6: B3 numerator and B4
   logic signed [N_W-1:0]    c6_n_in;
   logic [PNUM_W-1:0]        c6_b4p;
   logic signed [N_W-1:0]    c6_n_ff;
   logic [PDEN_W-1:0]        c6_b4_ff;
   logic signed [TEMP_W-1:0] c6_temp_ff;
   logic [UP_W-1:0]          c6_up_ff;
   logic                     c6_err_ff;

   assign c6_n_in = (N_W'(coef.ac1) <<< 2) + N_W'(c5_x3a_ff) + N_W'(2);
   assign c6_b4p  = c5_x3b_ff * PNUM_W'(coef.ac4);

   always_ff @(posedge clock) begin
      if (advance) begin
         c6_n_ff    <= c6_n_in;
         c6_b4_ff   <= c6_b4p[PNUM_W-1:PNUM_W-PDEN_W];
         c6_temp_ff <= c5_temp_ff;
         c6_up_ff   <= c5_up_ff;
         c6_err_ff  <= c5_err_ff;
      end
   end

   // stage 7: B3 and the raw pressure offset
   logic [NADJ_W-1:0]        c7_nadj;
   logic [PNUM_W-1:0]        c7_diff_in;
   logic [PNUM_W-1:0]        c7_diff_ff;
   logic [PDEN_W-1:0]        c7_b4_ff;
   logic signed [TEMP_W-1:0] c7_temp_ff;
   logic                     c7_err_ff;

   assign c7_nadj    = c6_n_ff[NADJ_W-1:0] + (c6_n_ff[N_W-1] ? NADJ_W'(3) : NADJ_W'(0));
   assign c7_diff_in = PNUM_W'(c6_up_ff) - c7_nadj[NADJ_W-1:2];

   always_ff @(posedge clock) begin
      if (advance) begin
         c7_diff_ff <= c7_diff_in;
         c7_b4_ff   <= c6_b4_ff;
         c7_temp_ff <= c6_temp_ff;
         c7_err_ff  <= c6_err_ff || (c6_b4_ff == '0);
      end
   end

   // stage 8: B7
   logic [PNUM_W-1:0]        c8_b7_in;
   logic [PNUM_W-1:0]        c8_b7_ff;
   logic [PDEN_W-1:0]        c8_b4_ff;
   logic signed [TEMP_W-1:0] c8_temp_ff;
   logic                     c8_err_ff;

   assign c8_b7_in = c7_diff_ff * PNUM_W'(PRESS_SCALE);

   always_ff @(posedge clock) begin
      if (advance) begin
         c8_b7_ff   <= c8_b7_in;
         c8_b4_ff   <= c7_b4_ff;
         c8_temp_ff <= c7_temp_ff;
         c8_err_ff  <= c7_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[7:1], in_valid};
      end
   end

   assign out_valid     = valid_ff[8];
   assign out_num       = c8_b7_ff[PNUM_W-1] ? c8_b7_ff : {c8_b7_ff[PNUM_W-2:0], 1'b0};
   assign out_den       = c8_b4_ff;
   assign out_side.temp = c8_temp_ff;
   assign out_side.dbl  = c8_b7_ff[PNUM_W-1];
   assign out_side.err  = c8_err_ff;

endmodule

// ===== rtl/brc_corr.sv =====
// Pressure correction polynomial and final saturation stages.
module brc_corr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [brc_pkg::PNUM_W-1:0] in_quo,
   input  brc_pkg::pdiv_side_type     in_side,
   output logic                       out_valid,
   output brc_pkg::rsp_type           out_rsp
);
   import brc_pkg::*;

   localparam int PS_W  = P_W - 8;
   localparam int SQP_W = 2 * PS_W;
   localparam int Y1P_W = SQP_W + 12;
   localparam int Y1_W  = Y1P_W - 16;
   localparam int MK_W  = P_W + 15;
   localparam int Y2_W  = MK_W - 16;
   localparam int SUM_W = Y1_W + 2;
   localparam int PF_W  = Y1_W + 3;

   logic [3:1] valid_ff;

   // stage 1: square and linear products
   logic [P_W-1:0]           r1_p_in;
   logic [PS_W-1:0]          r1_ps;
   logic [SQP_W-1:0]         r1_sq_in;
   logic signed [MK_W-1:0]   r1_m_in;
   logic [P_W-1:0]           r1_p_ff;
   logic [SQP_W-1:0]         r1_sq_ff;
   logic signed [MK_W-1:0]   r1_m_ff;
   logic signed [TEMP_W-1:0] r1_temp_ff;
   logic                     r1_err_ff;

   assign r1_p_in  = in_side.dbl ? {in_quo, 1'b0} : {1'b0, in_quo};
   assign r1_ps    = r1_p_in[P_W-1:8];
   assign r1_sq_in = r1_ps * r1_ps;
   assign r1_m_in  = MK_W'($signed({1'b0, r1_p_in})) * MK_W'(K2);

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_p_ff    <= r1_p_in;
         r1_sq_ff   <= r1_sq_in;
         r1_m_ff    <= r1_m_in;
         r1_temp_ff <= in_side.temp;
         r1_err_ff  <= in_side.err;
      end
   end

   // stage 2: scale the square term
   logic [Y1P_W-1:0]         r2_prod;
   logic [P_W-1:0]           r2_p_ff;
   logic [Y1_W-1:0]          r2_y1_ff;
   logic signed [Y2_W-1:0]   r2_y2_ff;
   logic signed [TEMP_W-1:0] r2_temp_ff;
   logic                     r2_err_ff;

   assign r2_prod = r1_sq_ff * Y1P_W'(K1);

   always_ff @(posedge clock) begin
      if (advance) begin
         r2_p_ff    <= r1_p_ff;
         r2_y1_ff   <= r2_prod[Y1P_W-1:16];
         r2_y2_ff   <= Y2_W'(r1_m_ff >>> 16);
         r2_temp_ff <= r1_temp_ff;
         r2_err_ff  <= r1_err_ff;
      end
   end

   // stage 3: corrected pressure
   logic signed [SUM_W-1:0]  r3_sum;
   logic signed [SUM_W-1:0]  r3_c;
   logic signed [PF_W-1:0]   r3_pf_in;
   logic signed [PF_W-1:0]   r3_pf_ff;
   logic signed [TEMP_W-1:0] r3_temp_ff;
   logic                     r3_err_ff;

   assign r3_sum   = $signed({2'b00, r2_y1_ff}) + SUM_W'(r2_y2_ff) + SUM_W'(K3);
   assign r3_c     = r3_sum >>> 4;
   assign r3_pf_in = PF_W'($signed({1'b0, r2_p_ff})) + PF_W'(r3_c);

   always_ff @(posedge clock) begin
      if (advance) begin
         r3_pf_ff   <= r3_pf_in;
         r3_temp_ff <= r2_temp_ff;
         r3_err_ff  <= r2_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:1], in_valid};
      end
   end

   always_comb begin
      out_rsp.math_error = r3_err_ff;
      if (r3_err_ff) begin
         out_rsp.temp_tenths = '0;
         out_rsp.pressure_pa = '0;
      end else begin
         out_rsp.temp_tenths = r3_temp_ff;
         if (r3_pf_ff < 0) begin
            out_rsp.pressure_pa = '0;
         end else if (r3_pf_ff > PF_W'(PRESS_MAX)) begin
            out_rsp.pressure_pa = PRESS_W'(PRESS_MAX);
         end else begin
            out_rsp.pressure_pa = r3_pf_ff[PRESS_W-1:0];
         end
      end
   end

   assign out_valid = valid_ff[3];

endmodule

// ===== rtl/barometer_reading_compensation.sv =====
// Top level: coefficient registers, front stages, dividers and output register.
// Throughput: one reading pair per cycle while no response beat is stalled; the
// 27-step temperature divider and the 32-step pressure divider are fully
// pipelined, one quotient bit per stage.
// A stalled response beat freezes every stage at once and holds req_stall high.
// Reset clears all valid bits, including the output register's, and the coefficients.
module barometer_reading_compensation (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  brc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output brc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [brc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [brc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import brc_pkg::*;

   localparam int TSIDE_W = $bits(tdiv_side_type);
   localparam int PSIDE_W = $bits(pdiv_side_type);

   logic     advance;
   coef_type coef_in;
   coef_type coef_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_AC1: coef_in.ac1 = csr_wdata[COEF_W-1:0];
            CSR_AC2: coef_in.ac2 = csr_wdata[COEF_W-1:0];
            CSR_AC3: coef_in.ac3 = csr_wdata[COEF_W-1:0];
            CSR_AC4: coef_in.ac4 = csr_wdata[COEF_W-1:0];
            CSR_AC5: coef_in.ac5 = csr_wdata[COEF_W-1:0];
            CSR_AC6: coef_in.ac6 = csr_wdata[COEF_W-1:0];
            CSR_B1_B2: begin
               coef_in.b1 = csr_wdata[2*COEF_W-1:COEF_W];
               coef_in.b2 = csr_wdata[COEF_W-1:0];
            end
            CSR_MC_MD: begin
               coef_in.mc = csr_wdata[2*COEF_W-1:COEF_W];
               coef_in.md = csr_wdata[COEF_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // front stage 1: raw temperature product
   logic signed [UT_W:0]       f1_diff;
   logic signed [2*UT_W+1:0]   f1_prod_in;
   logic signed [2*UT_W+1:0]   f1_prod_ff;
   logic [UP_W-1:0]            f1_up_ff;
   logic                       f1_valid_ff;

   assign f1_diff    = $signed({1'b0, req_data.ut}) - $signed({1'b0, coef_ff.ac6});
   assign f1_prod_in = f1_diff * $signed({1'b0, coef_ff.ac5});

   // front stage 2: divider operands
   logic signed [X1_W-1:0]   f2_x1;
   logic signed [X1_W:0]     f2_den;
   logic signed [TNUM_W-1:0] f2_num;
   logic [TNUM_W-1:0]        f2_num_abs_in;
   logic [X1_W:0]            f2_den_abs;
   tdiv_side_type            f2_side_in;
   logic [TNUM_W-1:0]        f2_num_ff;
   logic [TDEN_W-1:0]        f2_den_ff;
   tdiv_side_type            f2_side_ff;
   logic                     f2_valid_ff;

   assign f2_x1         = X1_W'(f1_prod_ff >>> 15);
   assign f2_den        = (X1_W+1)'(f2_x1) + (X1_W+1)'(coef_ff.md);
   assign f2_num        = TNUM_W'(coef_ff.mc) <<< MC_SHIFT;
   assign f2_num_abs_in = coef_ff.mc[COEF_W-1] ? TNUM_W'(-f2_num) : TNUM_W'(f2_num);
   assign f2_den_abs    = f2_den[X1_W] ? (X1_W+1)'(-f2_den) : (X1_W+1)'(f2_den);

   assign f2_side_in.x1  = f2_x1;
   assign f2_side_in.up  = f1_up_ff;
   assign f2_side_in.neg = coef_ff.mc[COEF_W-1] ^ f2_den[X1_W];
   assign f2_side_in.err = (f2_den == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_prod_ff <= f1_prod_in;
         f1_up_ff   <= req_data.up;
         f2_num_ff  <= f2_num_abs_in;
         f2_den_ff  <= f2_den_abs[TDEN_W-1:0];
         f2_side_ff <= f2_side_in;
      end
   end

   logic               tdiv_valid;
   logic [TNUM_W-1:0]  tdiv_quo;
   tdiv_side_type      tdiv_side;

   brc_div #(
      .NUM_W  (TNUM_W),
      .DEN_W  (TDEN_W),
      .SIDE_W (TSIDE_W)
   ) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f2_valid_ff),
      .in_num    (f2_num_ff),
      .in_den    (f2_den_ff),
      .in_side   (f2_side_ff),
      .out_valid (tdiv_valid),
      .out_quo   (tdiv_quo),
      .out_side  (tdiv_side)
   );

   logic              coef_valid;
   logic [PNUM_W-1:0] coef_num;
   logic [PDEN_W-1:0] coef_den;
   pdiv_side_type     coef_side;

   brc_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .coef      (coef_ff),
      .in_valid  (tdiv_valid),
      .in_quo    (tdiv_quo),
      .in_side   (tdiv_side),
      .out_valid (coef_valid),
      .out_num   (coef_num),
      .out_den   (coef_den),
      .out_side  (coef_side)
   );

   logic              pdiv_valid;
   logic [PNUM_W-1:0] pdiv_quo;
   pdiv_side_type     pdiv_side;

   brc_div #(
      .NUM_W  (PNUM_W),
      .DEN_W  (PDEN_W),
      .SIDE_W (PSIDE_W)
   ) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (coef_valid),
      .in_num    (coef_num),
      .in_den    (coef_den),
      .in_side   (coef_side),
      .out_valid (pdiv_valid),
      .out_quo   (pdiv_quo),
      .out_side  (pdiv_side)
   );

   logic    corr_valid;
   rsp_type corr_rsp;

   brc_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pdiv_valid),
      .in_quo    (pdiv_quo),
      .in_side   (pdiv_side),
      .out_valid (corr_valid),
      .out_rsp   (corr_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= corr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= corr_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/brc_checker.sv =====
// Port-level checker for the barometer compensation block, bound to the top level.
module brc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input brc_pkg::rsp_type rsp_data
);
   import brc_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response beat");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.math_error |->
         rsp_data.temp_tenths == '0 && rsp_data.pressure_pa == '0)
      else $error("math error beat carries nonzero results");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

endmodule

bind barometer_reading_compensation brc_checker u_brc_checker (.*);
